// ===== src/dlfs_pkg.sv =====
// ----------------------------------------------------------------------------
// dlfs_pkg
// Shared types, codes and constants of the decimal line filter with sum.
// ----------------------------------------------------------------------------
package dlfs_pkg;

  localparam int PATTERN_MAX_BYTES_DEF = 8;
  localparam int CFG_DATA_W            = 64;
  localparam int CFG_INDEX_W           = 2;
  localparam int THRESHOLD_W           = 31;
  localparam int SUM_W                 = 64;
  localparam int POS_W                 = 4;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

  localparam logic [1:0]             FILTER_MODE_RESET    = 2'd0;
  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET      = 31'd1000000;
  localparam logic [63:0]            PATTERN_RESET        = 64'd13563782407139377;
  localparam logic [3:0]             PATTERN_LENGTH_RESET = 4'd7;

  typedef enum logic [1:0] {
    MODE_LESS   = 2'd0,
    MODE_EXACT  = 2'd1,
    MODE_PREFIX = 2'd2
  } filter_mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FILTER_MODE    = 2'd0,
    REG_THRESHOLD      = 2'd1,
    REG_PATTERN_BYTES  = 2'd2,
    REG_PATTERN_LENGTH = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } byte_item_t;

  typedef struct packed {
    logic                    line_accepted;
    logic signed [SUM_W-1:0] running_sum;
    logic                    final_line;
  } result_item_t;

  typedef struct packed {
    logic [1:0]             filter_mode;
    logic [THRESHOLD_W-1:0] threshold;
    logic [3:0]             pattern_length;
  } cfg_t;

endpackage

// ===== src/decimal_line_filter_sum.sv =====
// ----------------------------------------------------------------------------
// decimal_line_filter_sum
// Parses newline-separated decimal lines one byte per item, filters each
// line and reports the verdict and running 64-bit sum at every line end.
//
// Channels: data_valid/data_stall/data_item carry one byte (or an
// end-of-data mark) per item; result_valid/result_stall/result_item carry
// one result per closed line. Bytes inside a line give no result.
// Configuration: wr_en/wr_index/wr_data; the user writes it only while idle, the block does not enforce it.
// Path: a line end is registered in the input register, then in the result
// register, before it appears on result_item.
// Throughput: one byte per cycle while no line end waits on a busy result register;
// the times-ten add and threshold compare between the input register and the line state set the cycle.
// Reset: registers return to their defaults, line state and sum clear.
// Stall: the result register holds its item; bytes that close no line keep
// flowing, and a line end waits in the input register until the result
// register frees, stalling the byte channel while it waits.
// ----------------------------------------------------------------------------
module decimal_line_filter_sum
  import dlfs_pkg::*;
#(
  parameter int PATTERN_MAX_BYTES = PATTERN_MAX_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  input  logic                   data_valid,
  output logic                   data_stall,
  input  byte_item_t             data_item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_item_t           result_item
);

  cfg_t                           cfg;
  logic [8*PATTERN_MAX_BYTES-1:0] pattern;
  logic                           res_busy;
  logic                           res_push;
  result_item_t                   res_item;

  dlfs_cfg #(
    .PATTERN_MAX_BYTES(PATTERN_MAX_BYTES)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg),
    .pattern  (pattern)
  );

  dlfs_core #(
    .PATTERN_MAX_BYTES(PATTERN_MAX_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pattern    (pattern),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_item  (data_item),
    .res_busy   (res_busy),
    .res_push   (res_push),
    .res_item   (res_item)
  );

  dlfs_out u_out (
    .clk          (clk),
    .rst          (rst),
    .res_push     (res_push),
    .res_item     (res_item),
    .res_busy     (res_busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

// ===== src/dlfs_cfg.sv =====
// ----------------------------------------------------------------------------
// dlfs_cfg
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module dlfs_cfg
  import dlfs_pkg::*;
#(
  parameter int PATTERN_MAX_BYTES = PATTERN_MAX_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [CFG_INDEX_W-1:0]         wr_index,
  input  logic [CFG_DATA_W-1:0]          wr_data,
  output cfg_t                           cfg,
  output logic [8*PATTERN_MAX_BYTES-1:0] pattern
);

  localparam int PW = 8 * PATTERN_MAX_BYTES;
  localparam logic [63:0] PAT_RST = PATTERN_RESET;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_mode    <= FILTER_MODE_RESET;
      cfg.threshold      <= THRESHOLD_RESET;
      cfg.pattern_length <= PATTERN_LENGTH_RESET;
      pattern            <= PAT_RST[PW-1:0];
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FILTER_MODE:    cfg.filter_mode    <= wr_data[1:0];
        REG_THRESHOLD:      cfg.threshold      <= wr_data[THRESHOLD_W-1:0];
        REG_PATTERN_BYTES:  pattern            <= wr_data[PW-1:0];
        REG_PATTERN_LENGTH: cfg.pattern_length <= wr_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/dlfs_core.sv =====
// ----------------------------------------------------------------------------
// dlfs_core
// Input register, line parse and filter, line state and running sum.
// ----------------------------------------------------------------------------
module dlfs_core
  import dlfs_pkg::*;
#(
  parameter int PATTERN_MAX_BYTES = PATTERN_MAX_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cfg_t                           cfg,
  input  logic [8*PATTERN_MAX_BYTES-1:0] pattern,
  input  logic                           data_valid,
  output logic                           data_stall,
  input  byte_item_t                     data_item,
  input  logic                           res_busy,
  output logic                           res_push,
  output result_item_t                   res_item
);

  localparam int VW = THRESHOLD_W + 4;

  logic                   s1_valid;
  byte_item_t             s1_item;
  logic                   advance;
  logic                   closes;

  logic [THRESHOLD_W-1:0] line_value, line_value_next;
  logic                   line_rejected, line_rejected_next;
  logic [POS_W-1:0]       byte_position, byte_position_next;
  logic [SUM_W-1:0]       total_sum, total_sum_next;

  logic                   is_digit;
  logic [3:0]             digit;
  logic [VW-1:0]          lv_wide;
  logic [VW-1:0]          value_new;
  logic [VW-1:0]          thr_wide;
  logic [3:0]             eff_len;
  logic [7:0]             want;
  logic                   accepted;
  logic [SUM_W-1:0]       addend;

  assign closes     = s1_item.end_of_data || (s1_item.data_byte == CHAR_NEWLINE);
  assign data_stall = s1_valid && closes && res_busy;
  assign advance    = s1_valid && !data_stall;
  assign res_push   = advance && closes;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (data_valid && !data_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && !data_stall) begin
      s1_item <= data_item;
    end
  end

  assign is_digit  = (s1_item.data_byte >= CHAR_ZERO) && (s1_item.data_byte <= CHAR_NINE);
  assign digit     = 4'(s1_item.data_byte - CHAR_ZERO);
  assign lv_wide   = VW'(line_value);
  assign value_new = (lv_wide << 3) + (lv_wide << 1) + VW'(digit);
  assign thr_wide  = VW'(cfg.threshold);
  assign eff_len   = (cfg.pattern_length > 4'(PATTERN_MAX_BYTES))
                     ? 4'(PATTERN_MAX_BYTES) : cfg.pattern_length;

  always_comb begin
    want = 8'h00;
    for (int i = 0; i < PATTERN_MAX_BYTES; i++) begin
      if (byte_position == 4'(i)) begin
        want = pattern[8*i +: 8];
      end
    end
  end

  always_comb begin
    accepted = 1'b0;
    addend   = '0;
    if (!line_rejected) begin
      case (cfg.filter_mode)
        MODE_LESS: begin
          accepted = 1'b1;
          addend   = SUM_W'(line_value);
        end
        MODE_EXACT: begin
          if (line_value == cfg.threshold) begin
            accepted = 1'b1;
            addend   = SUM_W'(cfg.threshold);
          end
        end
        MODE_PREFIX: begin
          if (byte_position >= eff_len) begin
            accepted = 1'b1;
            addend   = SUM_W'(cfg.threshold);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    line_value_next    = line_value;
    line_rejected_next = line_rejected;
    byte_position_next = byte_position;
    total_sum_next     = total_sum;
    if (advance) begin
      if (closes) begin
        total_sum_next     = total_sum + addend;
        line_value_next    = '0;
        line_rejected_next = 1'b0;
        byte_position_next = '0;
      end else begin
        if (byte_position != {POS_W{1'b1}}) begin
          byte_position_next = byte_position + 1'b1;
        end
        if (!line_rejected) begin
          case (cfg.filter_mode) inside
            MODE_LESS, MODE_EXACT: begin
              if (!is_digit) begin
                line_rejected_next = 1'b1;
              end else if ((cfg.filter_mode == MODE_LESS) ? (value_new >= thr_wide)
                                                          : (value_new > thr_wide)) begin
                line_rejected_next = 1'b1;
              end else begin
                line_value_next = value_new[THRESHOLD_W-1:0];
              end
            end
            MODE_PREFIX: begin
              if ((byte_position < eff_len) && (s1_item.data_byte != want)) begin
                line_rejected_next = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_value    <= '0;
      line_rejected <= 1'b0;
      byte_position <= '0;
      total_sum     <= '0;
    end else begin
      line_value    <= line_value_next;
      line_rejected <= line_rejected_next;
      byte_position <= byte_position_next;
      total_sum     <= total_sum_next;
    end
  end

  assign res_item.line_accepted = accepted;
  assign res_item.running_sum   = signed'(total_sum + addend);
  assign res_item.final_line    = s1_item.end_of_data;

endmodule

// ===== src/dlfs_out.sv =====
// ----------------------------------------------------------------------------
// dlfs_out
// Result register on the output channel; holds the item while stalled.
// ----------------------------------------------------------------------------
module dlfs_out
  import dlfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         res_push,
  input  result_item_t res_item,
  output logic         res_busy,
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result_item
);

  assign res_busy = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_push) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      result_item <= res_item;
    end
  end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Streams decimal and raw byte lines into the line filter, predicts each
// line verdict and running sum, and checks every result item in order across
// all filter modes, register extremes and idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import dlfs_pkg::*;

class line_sum_scoreboard;
  logic [1:0]             mode;
  logic [THRESHOLD_W-1:0] thr;
  logic [63:0]            pattern;
  logic [3:0]             plen;
  logic [31:0]            value;
  bit                     rejected;
  logic [POS_W-1:0]       pos;
  logic [SUM_W-1:0]       total;
  result_item_t           pending[$];
  int                     errors;

  function new();
    mode     = FILTER_MODE_RESET;
    thr      = THRESHOLD_RESET;
    pattern  = PATTERN_RESET;
    plen     = PATTERN_LENGTH_RESET;
    value    = '0;
    rejected = 1'b0;
    pos      = '0;
    total    = '0;
    errors   = 0;
  endfunction

  function void write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_FILTER_MODE: begin
        mode = d[1:0];
      end
      REG_THRESHOLD: begin
        thr = d[THRESHOLD_W-1:0];
      end
      REG_PATTERN_BYTES: begin
        pattern = d;
      end
      REG_PATTERN_LENGTH: begin
        plen = d[3:0];
      end
    endcase
  endfunction

  function int unsigned prefix_len();
    return (plen > PATTERN_MAX_BYTES_DEF) ? PATTERN_MAX_BYTES_DEF : plen;
  endfunction

  function void shift_in(logic [7:0] b);
    logic [POS_W-1:0] at;
    logic [63:0]      v;
    logic             over;
    at = pos;
    if (pos != 4'd15) pos = pos + 4'd1;
    if (rejected) return;
    if (mode == MODE_LESS || mode == MODE_EXACT) begin
      if (b < CHAR_ZERO || b > CHAR_NINE) begin
        rejected = 1'b1;
      end else begin
        v = {32'd0, value} * 64'd10 + {56'd0, 8'(b - CHAR_ZERO)};
        over = (mode == MODE_LESS) ? (v >= {33'd0, thr}) : (v > {33'd0, thr});
        if (over) rejected = 1'b1;
        else value = v[31:0];
      end
    end else if (mode == MODE_PREFIX && at < prefix_len()) begin
      if (b != pattern[8*at +: 8]) rejected = 1'b1;
    end
  endfunction

  function logic close_line();
    logic ok;
    ok = 1'b0;
    if (!rejected) begin
      if (mode == MODE_LESS) begin
        ok = 1'b1;
        total = total + {32'd0, value};
      end else if (mode == MODE_EXACT) begin
        if (value == {1'b0, thr}) begin
          ok = 1'b1;
          total = total + {33'd0, thr};
        end
      end else if (mode == MODE_PREFIX) begin
        if (pos >= prefix_len()) begin
          ok = 1'b1;
          total = total + {33'd0, thr};
        end
      end
    end
    value    = '0;
    rejected = 1'b0;
    pos      = '0;
    return ok;
  endfunction

  function void note_item(byte_item_t it);
    result_item_t r;
    if (!it.end_of_data && it.data_byte != CHAR_NEWLINE) begin
      shift_in(it.data_byte);
      return;
    end
    r.line_accepted = close_line();
    r.running_sum   = total;
    r.final_line    = it.end_of_data;
    pending.push_back(r);
  endfunction

  task report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task check_result(result_item_t got);
    result_item_t want;
    if (pending.size() == 0) begin
      report_mismatch($sformatf("unexpected result accepted=%b sum=%0d final=%b",
                                got.line_accepted, got.running_sum, got.final_line));
      return;
    end
    want = pending.pop_front();
    if (got.line_accepted !== want.line_accepted)
      report_mismatch($sformatf("line_accepted %b, want %b",
                                got.line_accepted, want.line_accepted));
    if (got.running_sum !== want.running_sum)
      report_mismatch($sformatf("running_sum %0d, want %0d",
                                got.running_sum, want.running_sum));
    if (got.final_line !== want.final_line)
      report_mismatch($sformatf("final_line %b, want %b",
                                got.final_line, want.final_line));
  endtask
endclass

module tb_top;
  import dlfs_pkg::*;

  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 4;
  localparam int ROUND_ITEMS   = 55;

  typedef logic [7:0] byte_q_t[$];

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   wr_en        = 1'b0;
  logic [CFG_INDEX_W-1:0] wr_index     = '0;
  logic [CFG_DATA_W-1:0]  wr_data      = '0;
  logic                   data_valid   = 1'b0;
  logic                   data_stall;
  byte_item_t             data_item    = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_item_t           result_item;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles   = 0;
  int sent_items    = 0;

  line_sum_scoreboard sums = new();

  decimal_line_filter_sum dut (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_item    (data_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sums.check_result(result_item);
    if (rst || (data_valid && !data_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic byte_q_t decimal_of(longint unsigned v);
    string   s;
    byte_q_t q;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic byte_q_t random_digits(int n);
    byte_q_t q;
    repeat (n) q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    return q;
  endfunction

  function automatic byte_q_t random_bytes(int n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_NEWLINE);
    return b;
  endfunction

  function automatic byte_q_t numeric_line();
    longint unsigned t;
    byte_q_t         q;
    t = sums.thr;
    case ($urandom_range(0, 9))
      0: q.delete();
      1: q = decimal_of(t);
      2: q = decimal_of((t == 0) ? 0 : t - 1);
      3: q = decimal_of(t + 1);
      4: q = decimal_of($urandom_range(0, t));
      5: begin
        q = decimal_of(t);
        q.push_front(CHAR_ZERO);
        q.push_front(CHAR_ZERO);
      end
      6: q = random_digits($urandom_range(1, 12));
      7: begin
        q = decimal_of($urandom_range(0, t));
        q.insert($urandom_range(0, q.size()), non_digit());
      end
      8: q = random_digits($urandom_range(1, 3));
      default: q = random_bytes($urandom_range(0, 8));
    endcase
    return q;
  endfunction

  function automatic byte_q_t prefix_line();
    int unsigned eff;
    int          k;
    byte_q_t     q;
    eff = sums.prefix_len();
    case ($urandom_range(0, 5))
      0, 1: begin
        for (int i = 0; i < eff; i++) q.push_back(sums.pattern[8*i +: 8]);
        q = {q, random_bytes($urandom_range(0, 4))};
      end
      2: begin
        for (int i = 0; i < eff; i++) q.push_back(sums.pattern[8*i +: 8]);
        if (eff > 0) q[$urandom_range(0, eff - 1)] ^= 8'(1 << $urandom_range(0, 7));
      end
      3: begin
        k = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
        for (int i = 0; i < k; i++) q.push_back(sums.pattern[8*i +: 8]);
      end
      4: q.delete();
      default: q = random_bytes($urandom_range(0, 10));
    endcase
    return q;
  endfunction

  function automatic byte_q_t random_line();
    if ($urandom_range(0, 11) == 0) return random_bytes($urandom_range(0, 12));
    if (sums.mode == MODE_PREFIX) return prefix_line();
    if (sums.mode == MODE_LESS || sums.mode == MODE_EXACT) return numeric_line();
    return ($urandom_range(0, 1) == 0) ? numeric_line() : prefix_line();
  endfunction

  task automatic send_item(byte_item_t it);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      data_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    data_valid <= 1'b1;
    data_item  <= it;
    do @(posedge clk); while (data_stall);
    sums.note_item(it);
    sent_items++;
  endtask

  task automatic send_bytes(byte_q_t body);
    byte_item_t it;
    foreach (body[i]) begin
      it.data_byte   = body[i];
      it.end_of_data = 1'b0;
      send_item(it);
    end
  endtask

  task automatic send_line(byte_q_t body, bit eod);
    byte_item_t it;
    send_bytes(body);
    it.end_of_data = eod;
    it.data_byte   = eod ? 8'($urandom_range(0, 255)) : CHAR_NEWLINE;
    send_item(it);
  endtask

  task automatic drain();
    data_valid <= 1'b0;
    do @(posedge clk); while (sums.pending.size() != 0);
  endtask

  task automatic put_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] d);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= d;
    @(posedge clk);
    sums.write_reg(idx, d);
  endtask

  task automatic set_config(logic [1:0] mode, logic [THRESHOLD_W-1:0] thr,
                            logic [63:0] pat, logic [3:0] plen);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    put_reg(REG_FILTER_MODE, {62'd0, mode});
    put_reg(REG_THRESHOLD, {33'd0, thr});
    put_reg(REG_PATTERN_BYTES, pat);
    put_reg(REG_PATTERN_LENGTH, {60'd0, plen});
    wr_en <= 1'b0;
  endtask

  task automatic run_round(int r);
    logic [THRESHOLD_W-1:0] thr;
    logic [63:0]            pat;
    logic [7:0]             b;
    logic [3:0]             plen;
    int                     start;
    case (r % 5)
      0: thr = '0;
      1: thr = '1;
      2: thr = THRESHOLD_W'($urandom_range(0, 20));
      3: thr = THRESHOLD_W'($urandom_range(0, 99999));
      default: thr = THRESHOLD_W'($urandom);
    endcase
    case (r % 7)
      0: pat = '0;
      1: pat = '1;
      default: begin
        for (int i = 0; i < 8; i++) begin
          b = 8'($urandom_range(0, 255));
          if (b == CHAR_NEWLINE) b = CHAR_ZERO;
          pat[8*i +: 8] = b;
        end
      end
    endcase
    case (r % 6)
      0: plen = 4'd0;
      1: plen = 4'd8;
      2: plen = 4'd15;
      3: plen = 4'd1;
      default: plen = 4'($urandom_range(0, 15));
    endcase
    // leave a line open across the register change
    if (r % 3 == 2) send_bytes(random_digits($urandom_range(1, 4)));
    set_config(2'(r % 4), thr, pat, plen);
    start = sent_items;
    while (sent_items - start < ROUND_ITEMS) begin
      send_line(random_line(), $urandom_range(0, 9) == 0);
      if ($urandom_range(0, 29) == 0) drain();
    end
  endtask

  initial begin
    byte_q_t q;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    q.delete();
    send_line(q, 1'b0);
    send_line(decimal_of(999999), 1'b0);
    send_line(decimal_of(1000000), 1'b0);
    q = decimal_of(1);
    q.push_back(8'h61);
    send_line(q, 1'b0);
    q.delete();
    q.push_back(CHAR_ZERO - 8'd1);
    send_line(q, 1'b0);
    q.delete();
    q.push_back(CHAR_NINE + 8'd1);
    send_line(q, 1'b0);
    send_line(decimal_of(42), 1'b1);
    q.delete();
    send_line(q, 1'b1);

    send_idle_pct = 27;
    recv_idle_pct = 63;
    for (int r = 0; r < 5; r++) run_round(r);
    send_idle_pct = 63;
    recv_idle_pct = 27;
    for (int r = 5; r < 10; r++) run_round(r);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int r = 10; r < 15; r++) run_round(r);

    drain();
    repeat (8) @(posedge clk);
    if (sums.errors == 0 && sums.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
